// ===== src/pfe_pkg.sv =====
// Package for the palette fade engine: types, constants and field helpers.
// No dependencies; pfe_div and the top level use it by scoped names.
package pfe_pkg;

    localparam int PALETTE_ENTRIES_DEF    = 256;
    localparam int EFFECT_SLOTS_DEF       = 4;
    localparam int ENTRIES_PER_RESULT_DEF = 4;
    localparam int SLOT_W   = 46;
    localparam int COLOR_W  = 18;
    localparam int COMP_W   = 6;
    localparam int FRAME_W  = 16;
    localparam int STEPS_W  = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] FADE_IN  = 2'd1;
    localparam logic [1:0] FADE_OUT = 2'd2;
    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_FRAME = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_STORE,
        ST_EMIT,
        ST_PASS
    } state_t;

    // Divider request/response travel as structs
    typedef struct packed {
        logic               start;
        logic signed [16:0] dividend;
        logic [9:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [16:0] quotient;
    } div_rsp_t;

    function automatic logic slot_enabled(input logic [SLOT_W-1:0] w);
        return (w[27:26] == FADE_IN || w[27:26] == FADE_OUT) && (w[25:16] != 10'd0);
    endfunction

endpackage

// ===== src/pfe_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/pfe_div.sv =====
// Shared restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on pfe_pkg.
module pfe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pfe_pkg::div_req_t req,
    output pfe_pkg::div_rsp_t rsp
);
    logic [16:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [9:0]  den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] trial;
    logic [16:0] mag;

    assign mag   = req.dividend[16] ? 17'(-req.dividend) : 17'(req.dividend);
    assign trial = {rem_reg, quo_reg[16]} - {8'd0, den_reg};

    // Shift in one dividend bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            den_next  = req.divisor;
            neg_next  = req.dividend[16];
            cnt_next  = 5'd17;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[17])
            begin
                rem_next = trial[16:0];
                quo_next = {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[15:0], quo_reg[16]};
                quo_next = {quo_reg[15:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
endmodule

// ===== src/palette_fade_engine.sv =====
// Palette fade engine top level: config slots, sequencer, palette RAM, divider.
// Depends on pfe_pkg, pfe_ram and pfe_div.
// A passed-through palette write enters the pass state, which then registers m_tvalid.
// A matching frame tick reads and loads each entry, runs the divider once per color
// component, and emits one result per group of entries once the output is free.
// Reset: control, flags and slots clear at once; palette has valid bits per entry.
module palette_fade_engine #(
    parameter int PALETTE_ENTRIES    = pfe_pkg::PALETTE_ENTRIES_DEF,
    parameter int EFFECT_SLOTS       = pfe_pkg::EFFECT_SLOTS_DEF,
    parameter int ENTRIES_PER_RESULT = pfe_pkg::ENTRIES_PER_RESULT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // entry_index[7:0], red_in[13:8], green_in[19:14], blue_in[25:20],
    // frame_number[41:26]
    input  logic [47:0] s_tdata,
    // operation[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // base_index[7:0], entry_count[10:8], color_a[28:11], color_b[46:29],
    // color_c[64:47], color_d[82:65]
    output logic [87:0] m_tdata,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfe_pkg::SLOT_W-1:0]    cfg_data
);
    localparam int AW  = $clog2(PALETTE_ENTRIES);
    localparam int LW  = (ENTRIES_PER_RESULT > 1) ? $clog2(ENTRIES_PER_RESULT) : 1;

    pfe_pkg::state_t state_reg, state_next;
    logic [pfe_pkg::SLOT_W-1:0] slot_reg [EFFECT_SLOTS];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic inside_reg, inside_next, seen_reg, seen_next;
    logic [AW:0]  ent_reg, ent_next;
    logic [LW-1:0] lane_reg, lane_next;
    logic [1:0]   comp_reg, comp_next;
    logic [pfe_pkg::SLOT_W-1:0] eff_reg, eff_next;
    logic [pfe_pkg::FRAME_W-1:0] step_reg, step_next;
    logic [pfe_pkg::COLOR_W-1:0] src_reg, src_next;
    logic [pfe_pkg::COLOR_W-1:0] cols_reg [4];
    logic [pfe_pkg::COLOR_W-1:0] cols_next [4];
    logic [7:0]  base_reg, base_next;
    logic        mvalid_reg, mvalid_next, mlast_reg, mlast_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [87:0] mdata_reg, mdata_next;

    logic        accept, wr_in, wr_ok, blocked, hit, div_go;
    logic [pfe_pkg::SLOT_W-1:0] hit_slot;
    logic [pfe_pkg::FRAME_W-1:0] frame;
    logic [pfe_pkg::COLOR_W-1:0] wcolor, ram_q, src_val;
    logic [AW-1:0] raddr;
    logic [5:0]  c0, d0, d1, res6;
    pfe_pkg::div_req_t dreq;
    pfe_pkg::div_rsp_t drsp;

    assign accept = s_tvalid && s_tready;
    assign frame  = s_tdata[41:26];
    assign wcolor = s_tdata[25:8];
    assign wr_in  = accept && (s_tuser == pfe_pkg::OP_WRITE);
    assign wr_ok  = {1'b0, s_tdata[7:0]} < 9'(PALETTE_ENTRIES);
    assign cfg_ready = (state_reg == pfe_pkg::ST_IDLE) && !mvalid_reg;
    assign s_tready  = (state_reg == pfe_pkg::ST_IDLE) && !mvalid_reg;

    pfe_ram #(.WIDTH(pfe_pkg::COLOR_W), .DEPTH(PALETTE_ENTRIES)) u_ram (
        .clk   (clk),
        .we    (wr_in && wr_ok),
        .waddr (AW'(s_tdata[7:0])),
        .wdata (wcolor),
        .raddr (raddr),
        .rdata (ram_q)
    );

    pfe_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign raddr = ent_reg[AW-1:0];
    assign src_val = valid_reg[raddr] ? ram_q : '0;

    // Pick first matching slot and pre-frame blocking
    always_comb
    begin
        hit = 1'b0;
        hit_slot = '0;
        blocked = 1'b0;
        for (int i = EFFECT_SLOTS - 1; i >= 0; i--)
        begin
            if (pfe_pkg::slot_enabled(slot_reg[i]) && frame >= slot_reg[i][15:0] &&
                {1'b0, frame} < {1'b0, slot_reg[i][15:0]} + 17'(slot_reg[i][25:16]))
            begin
                hit = 1'b1;
                hit_slot = slot_reg[i];
            end
            if (pfe_pkg::slot_enabled(slot_reg[i]) && slot_reg[i][15:0] <= 16'd1)
            begin
                blocked = 1'b1;
            end
        end
        if (seen_reg)
        begin
            blocked = inside_reg;
        end
    end

    // Select the finishing component for the result and the next one for the divider
    always_comb
    begin
        logic [1:0] nc;
        logic [pfe_pkg::COLOR_W-1:0] sv;
        logic [5:0] s, e, ns, ne;
        nc = (state_reg == pfe_pkg::ST_STORE || comp_reg == 2'd2) ? 2'd0 :
             comp_reg + 2'd1;
        sv = (state_reg == pfe_pkg::ST_STORE) ? src_val : src_reg;
        s  = src_reg[comp_reg*6 +: 6];
        e  = eff_reg[28 + comp_reg*6 +: 6];
        ns = sv[nc*6 +: 6];
        ne = eff_reg[28 + nc*6 +: 6];
        if (eff_reg[27:26] == pfe_pkg::FADE_IN)
        begin
            c0 = e;
            d0 = ne;
            d1 = ns;
        end
        else
        begin
            c0 = s;
            d0 = ns;
            d1 = ne;
        end
    end

    assign dreq.start    = div_go;
    assign dreq.dividend = 17'(($signed({1'b0, d0}) - $signed({1'b0, d1})) *
                               $signed({1'b0, step_reg[10:0]}));
    assign dreq.divisor  = eff_reg[25:16];
    assign res6 = 6'(c0 - drsp.quotient[5:0]);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pfe_pkg::ST_IDLE:
                if (accept)
                begin
                    if (s_tuser == pfe_pkg::OP_FRAME)
                        state_next = hit ? pfe_pkg::ST_READ : pfe_pkg::ST_IDLE;
                    else if (wr_ok && !blocked)
                        state_next = pfe_pkg::ST_PASS;
                end
            pfe_pkg::ST_READ:  state_next = pfe_pkg::ST_STORE;
            pfe_pkg::ST_STORE: state_next = pfe_pkg::ST_DIV;
            pfe_pkg::ST_DIV:
                if (drsp.done && comp_reg == 2'd2)
                    state_next = (lane_reg == LW'(ENTRIES_PER_RESULT - 1) ||
                                  ent_reg == (AW+1)'(PALETTE_ENTRIES - 1)) ?
                                 pfe_pkg::ST_EMIT : pfe_pkg::ST_READ;
            pfe_pkg::ST_EMIT:
                if (!mvalid_reg)
                    state_next = (ent_reg == (AW+1)'(PALETTE_ENTRIES)) ?
                                 pfe_pkg::ST_IDLE : pfe_pkg::ST_READ;
            pfe_pkg::ST_PASS:  state_next = pfe_pkg::ST_IDLE;
            default:           state_next = pfe_pkg::ST_IDLE;
        endcase
    end

    assign div_go = (state_reg == pfe_pkg::ST_STORE) ||
                    (state_reg == pfe_pkg::ST_DIV && drsp.done && comp_reg != 2'd2);

    // Datapath and outputs
    always_comb
    begin
        inside_next = inside_reg;
        seen_next   = seen_reg;
        ent_next    = ent_reg;
        lane_next   = lane_reg;
        comp_next   = comp_reg;
        eff_next    = eff_reg;
        step_next   = step_reg;
        src_next    = src_reg;
        cols_next   = cols_reg;
        base_next   = base_reg;
        cnt_next    = cnt_reg;
        mdata_next  = mdata_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mlast_next  = mlast_reg;
        unique case (state_reg)
            pfe_pkg::ST_IDLE:
                if (accept)
                begin
                    if (s_tuser == pfe_pkg::OP_FRAME)
                    begin
                        seen_next   = 1'b1;
                        inside_next = hit;
                        eff_next    = hit_slot;
                        step_next   = frame - hit_slot[15:0] + 16'd1;
                        ent_next    = '0;
                        lane_next   = '0;
                        for (int j = 0; j < 4; j++) cols_next[j] = '0;
                    end
                    else
                    begin
                        cols_next[0] = wcolor;
                        for (int j = 1; j < 4; j++) cols_next[j] = '0;
                        base_next = s_tdata[7:0];
                        cnt_next  = 3'd1;
                    end
                end
            pfe_pkg::ST_STORE:
            begin
                src_next  = src_val;
                comp_next = 2'd0;
            end
            pfe_pkg::ST_DIV:
                if (drsp.done)
                begin
                    cols_next[lane_reg][comp_reg*6 +: 6] = res6;
                    comp_next = (comp_reg == 2'd2) ? 2'd0 : comp_reg + 2'd1;
                    if (comp_reg == 2'd2)
                    begin
                        ent_next  = ent_reg + 1'b1;
                        lane_next = lane_reg + 1'b1;
                    end
                end
            pfe_pkg::ST_EMIT:
                if (!mvalid_reg)
                begin
                    mvalid_next = 1'b1;
                    mlast_next  = ent_reg == (AW+1)'(PALETTE_ENTRIES);
                    cnt_next    = 3'(lane_reg == '0 ? ENTRIES_PER_RESULT : lane_reg);
                    base_next   = 8'(ent_reg - (AW+1)'(cnt_next));
                    mdata_next  = {5'd0, cols_reg[3], cols_reg[2], cols_reg[1],
                                   cols_reg[0], cnt_next, base_next};
                    lane_next   = '0;
                end
            pfe_pkg::ST_PASS:
            begin
                mvalid_next = 1'b1;
                mlast_next  = 1'b1;
                mdata_next  = {5'd0, cols_reg[3], cols_reg[2], cols_reg[1], cols_reg[0],
                               cnt_reg, base_reg};
            end
            default: ;
        endcase
        if (state_reg == pfe_pkg::ST_READ && lane_reg == '0)
        begin
            for (int j = 0; j < 4; j++) cols_next[j] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= pfe_pkg::ST_IDLE;
            inside_reg <= 1'b0;
            seen_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
            valid_reg  <= '0;
            ent_reg    <= '0;
            lane_reg   <= '0;
            comp_reg   <= '0;
            for (int i = 0; i < EFFECT_SLOTS; i++) slot_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            inside_reg <= inside_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
            ent_reg    <= ent_next;
            lane_reg   <= lane_next;
            comp_reg   <= comp_next;
            if (wr_in && wr_ok)
                valid_reg[AW'(s_tdata[7:0])] <= 1'b1;
            if (cfg_valid && cfg_ready && {1'b0, cfg_index} < 3'(EFFECT_SLOTS))
                slot_reg[cfg_index[$clog2(EFFECT_SLOTS > 1 ? EFFECT_SLOTS : 2)-1:0]]
                    <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        eff_reg  <= eff_next;
        step_reg <= step_next;
        src_reg  <= src_next;
        cols_reg <= cols_next;
        base_reg <= base_next;
        cnt_reg  <= cnt_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = mdata_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != pfe_pkg::ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:8] != 3'd0)) else $error("zero entry count");
endmodule
